[hw/rtl/tl_pkg.sv]
// tl_pkg: request and result types, token kinds, lexer modes and keyword table
// for the token lexer; no dependencies
package tl_pkg;

    // one source request and one token result
    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
    } t_req;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [15:0] line_number;
        logic [23:0] start_offset;
        logic [15:0] lexeme_length;
        logic [7:0]  char_value;
        logic        last_of_run;
    } t_res;

    // request op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_IDENT  = 4'd1,
        M_NUM    = 4'd2,
        M_EQ     = 4'd3,
        M_GT     = 4'd4,
        M_LT     = 4'd5,
        M_BANG   = 4'd6,
        M_CHOPEN = 4'd7,
        M_CHVAL  = 4'd8,
        M_STR    = 4'd9,
        M_HALT   = 4'd10
    } t_mode;

    // token kinds
    localparam logic [5:0] K_ID      = 6'd0;
    localparam logic [5:0] K_NUM     = 6'd13;
    localparam logic [5:0] K_LPAREN  = 6'd14;
    localparam logic [5:0] K_RPAREN  = 6'd15;
    localparam logic [5:0] K_LBRACE  = 6'd16;
    localparam logic [5:0] K_RBRACE  = 6'd17;
    localparam logic [5:0] K_LBRACK  = 6'd18;
    localparam logic [5:0] K_RBRACK  = 6'd19;
    localparam logic [5:0] K_EQEQ    = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_GE      = 6'd22;
    localparam logic [5:0] K_GT      = 6'd23;
    localparam logic [5:0] K_LE      = 6'd24;
    localparam logic [5:0] K_LT      = 6'd25;
    localparam logic [5:0] K_NE      = 6'd26;
    localparam logic [5:0] K_CHARLIT = 6'd27;
    localparam logic [5:0] K_STR     = 6'd28;
    localparam logic [5:0] K_SEMI    = 6'd29;
    localparam logic [5:0] K_COMMA   = 6'd30;
    localparam logic [5:0] K_PLUS    = 6'd31;
    localparam logic [5:0] K_MINUS   = 6'd32;
    localparam logic [5:0] K_STAR    = 6'd33;
    localparam logic [5:0] K_SLASH   = 6'd34;
    localparam logic [5:0] K_ERROR   = 6'd35;
    localparam logic [5:0] K_NOQUOTE = 6'd36;
    localparam logic [5:0] K_END     = 6'd37;
    localparam logic [5:0] K_BANG    = 6'd38;

    // keyword table, kind of keyword k is k + 1
    localparam int KW_COUNT = 12;
    localparam int KW_MAXLEN = 6;

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"a", "n", "d", 8'h00, 8'h00, 8'h00},
        '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "o", "t", 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"m", "a", "i", "n", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"i", "n", "p", "u", "t", 8'h00},
        '{"o", "u", "t", "p", "u", "t"}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd2, 3'd5, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd4, 3'd5, 3'd6
    };

endpackage

[hw/rtl/token_lexer.sv]
// token_lexer: character-at-a-time lexer, one request register, one pass of
// lexing logic and a four-entry result queue; depends on tl_pkg
//
//  channel  | valid       | stall        | payload               | per request
//  ---------+-------------+--------------+-----------------------+-------------
//  request  | i_in_valid  | o_in_stall   | i_in_req  (t_req)     | in
//  result   | o_out_valid | i_out_stall  | o_out_res (t_res)     | 0 to 2 out
//
// a new request can be taken every cycle unless stalled; a request gives at
// most two results, the queue drains one per cycle unless stalled, so runs of
// two-result requests are paced by the result port
// lexing waits while fewer than two queue entries are free, and the request
// register then holds its request and raises o_in_stall
// reset (synchronous, active low) empties both stages and puts the lexer in
// its idle mode with line 1 and offset 0; there is no clearing pass
module token_lexer
    import tl_pkg::*;
#(
    parameter int LINE_BITS = 16,
    parameter int POS_BITS  = 24,
    parameter int LEN_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_res
);

    // request register
    logic r_in_vld;
    t_req r_in;

    // lexer state
    t_mode                 r_mode, n_mode;
    logic [LINE_BITS-1:0]  r_line, n_line;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_tstart, n_tstart;
    logic [LEN_BITS-1:0]   r_tlen, n_tlen;
    logic [KW_COUNT-1:0]   r_mask, n_mask;
    logic [7:0]            r_held, n_held;

    // result queue
    t_res       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    logic       go, in_acc, out_pop;
    logic [7:0] c;
    logic       c_alpha, c_digit;

    logic [LINE_BITS-1:0] line_inc;
    logic [POS_BITS-1:0]  pos_inc;
    logic [LEN_BITS-1:0]  len_inc;

    logic [KW_COUNT-1:0] nar_mask, nar0_mask;
    logic [5:0]          id_kind;

    // pending token of the current mode
    logic                pend;
    logic [5:0]          fl_kind;
    logic [LEN_BITS-1:0] fl_len;
    logic [7:0]          fl_cv;

    // first and second candidate result of this request
    logic                a_v, b_v, do_idle;
    logic [5:0]          a_kind, b_kind;
    logic [POS_BITS-1:0] a_start, b_start;
    logic [LEN_BITS-1:0] a_len, b_len;
    logic [7:0]          a_cv, b_cv;

    t_res       s0, s1;
    logic [1:0] n_res;

    // build one result, fitting the parameter widths to the field widths
    function automatic t_res mk_res(input logic [5:0] kind, input logic [LINE_BITS-1:0] ln,
                                    input logic [POS_BITS-1:0] st,
                                    input logic [LEN_BITS-1:0] len, input logic [7:0] cv,
                                    input logic last);
        t_res        r;
        logic [31:0] ln_w, st_w, len_w;
        ln_w  = 32'(ln);
        st_w  = 32'(st);
        len_w = 32'(len);
        r.token_kind    = kind;
        r.line_number   = ln_w[15:0];
        r.start_offset  = st_w[23:0];
        r.lexeme_length = len_w[15:0];
        r.char_value    = cv;
        r.last_of_run   = last;
        return r;
    endfunction

    // handshakes
    assign go          = r_in_vld && (r_cnt <= 3'd2);
    assign o_in_stall  = r_in_vld && !go;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_cnt != 3'd0);
    assign out_pop     = o_out_valid && !i_out_stall;
    assign o_out_res   = r_q[r_rp];

    // character classes
    assign c       = r_in.char_code;
    assign c_alpha = (c == "_") || (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
    assign c_digit = c inside {["0":"9"]};

    // saturating counters
    assign line_inc = (r_line == '1) ? r_line : r_line + 1'b1;
    assign pos_inc  = (r_pos == '1) ? r_pos : r_pos + 1'b1;
    assign len_inc  = (r_tlen == '1) ? r_tlen : r_tlen + 1'b1;

    // keyword candidates: narrowed at the current length, and for a fresh
    // identifier at place zero; kind is the first survivor of matching length
    always_comb begin
        nar_mask  = '0;
        nar0_mask = '0;
        id_kind   = K_ID;
        for (int k = 0; k < KW_COUNT; k++) begin
            nar_mask[k]  = (r_tlen < LEN_BITS'(KW_MAXLEN)) &&
                           (KW_TEXT[k][r_tlen[2:0]] == c);
            nar0_mask[k] = (KW_TEXT[k][0] == c);
        end
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (r_mask[k] && (LEN_BITS'(KW_LEN[k]) == r_tlen)) begin
                id_kind = 6'(k + 1);
            end
        end
    end

    // token pending in the current mode
    always_comb begin
        pend    = 1'b1;
        fl_kind = K_NOQUOTE;
        fl_len  = r_tlen;
        fl_cv   = 8'h00;
        case (r_mode)
            M_IDENT: begin
                fl_kind = id_kind;
            end
            M_NUM: begin
                fl_kind = K_NUM;
            end
            M_EQ: begin
                fl_kind = K_ASSIGN;
                fl_len  = LEN_BITS'(1);
                fl_cv   = "=";
            end
            M_GT: begin
                fl_kind = K_GT;
                fl_len  = LEN_BITS'(1);
                fl_cv   = ">";
            end
            M_LT: begin
                fl_kind = K_LT;
                fl_len  = LEN_BITS'(1);
                fl_cv   = "<";
            end
            M_BANG: begin
                fl_kind = K_BANG;
                fl_len  = LEN_BITS'(1);
                fl_cv   = "!";
            end
            M_CHOPEN, M_STR: begin
                fl_kind = K_NOQUOTE;
            end
            M_CHVAL: begin
                fl_kind = K_NOQUOTE;
                fl_cv   = r_held;
            end
            default: begin
                pend = 1'b0;
            end
        endcase
    end

    // one lexing pass: next state and up to two candidate results
    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_tlen   = r_tlen;
        n_mask   = r_mask;
        n_held   = r_held;
        a_v      = 1'b0;
        a_kind   = fl_kind;
        a_start  = r_tstart;
        a_len    = fl_len;
        a_cv     = fl_cv;
        b_v      = 1'b0;
        b_kind   = K_ERROR;
        b_start  = r_pos;
        b_len    = LEN_BITS'(1);
        b_cv     = c;
        do_idle  = 1'b0;

        if (r_in.op == OP_END) begin
            // flush whatever is pending, then the end token, then full reset
            a_v      = pend;
            b_v      = 1'b1;
            b_kind   = K_END;
            b_len    = '0;
            b_cv     = 8'h00;
            n_mode   = M_IDLE;
            n_line   = LINE_BITS'(1);
            n_pos    = '0;
            n_tstart = '0;
            n_tlen   = '0;
            n_mask   = '1;
            n_held   = 8'h00;
        end else if (r_mode != M_HALT) begin
            n_pos = pos_inc;
            case (r_mode)
                M_IDENT: begin
                    if (c_alpha) begin
                        n_mask = r_mask & nar_mask;
                        n_tlen = len_inc;
                    end else begin
                        a_v     = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_NUM: begin
                    if (c_digit) begin
                        n_tlen = len_inc;
                    end else begin
                        a_v     = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_EQ, M_GT, M_LT, M_BANG: begin
                    if (c == "=") begin
                        // two-character operator
                        a_v    = 1'b1;
                        a_len  = LEN_BITS'(2);
                        a_cv   = 8'h00;
                        n_mode = M_IDLE;
                        case (r_mode)
                            M_EQ:    a_kind = K_EQEQ;
                            M_GT:    a_kind = K_GE;
                            M_LT:    a_kind = K_LE;
                            default: a_kind = K_NE;
                        endcase
                    end else begin
                        a_v     = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_CHOPEN: begin
                    n_held = c;
                    n_tlen = LEN_BITS'(2);
                    n_mode = M_CHVAL;
                end
                M_CHVAL: begin
                    // closing byte is consumed whether it is a quote or not
                    n_tlen = LEN_BITS'(3);
                    a_v    = 1'b1;
                    a_kind = (c == "'") ? K_CHARLIT : K_NOQUOTE;
                    a_len  = LEN_BITS'(3);
                    a_cv   = r_held;
                    n_mode = M_IDLE;
                end
                M_STR: begin
                    n_tlen = len_inc;
                    if (c == "\"") begin
                        a_v    = 1'b1;
                        a_kind = K_STR;
                        a_len  = len_inc;
                        a_cv   = 8'h00;
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_idle) begin
                n_mode = M_IDLE;
                if (c == " " || c == "\t") begin
                    // blank, nothing to do
                end else if (c == "\n") begin
                    n_line = line_inc;
                end else if (c_alpha) begin
                    n_mode   = M_IDENT;
                    n_tstart = r_pos;
                    n_tlen   = LEN_BITS'(1);
                    n_mask   = nar0_mask;
                end else if (c_digit) begin
                    n_mode   = M_NUM;
                    n_tstart = r_pos;
                    n_tlen   = LEN_BITS'(1);
                end else begin
                    case (c)
                        "=", ">", "<", "!", "'", "\"": begin
                            n_tstart = r_pos;
                            n_tlen   = LEN_BITS'(1);
                            case (c)
                                "=":     n_mode = M_EQ;
                                ">":     n_mode = M_GT;
                                "<":     n_mode = M_LT;
                                "!":     n_mode = M_BANG;
                                "'":     n_mode = M_CHOPEN;
                                default: n_mode = M_STR;
                            endcase
                        end
                        "(": begin b_v = 1'b1; b_kind = K_LPAREN; end
                        ")": begin b_v = 1'b1; b_kind = K_RPAREN; end
                        "{": begin b_v = 1'b1; b_kind = K_LBRACE; end
                        "}": begin b_v = 1'b1; b_kind = K_RBRACE; end
                        "[": begin b_v = 1'b1; b_kind = K_LBRACK; end
                        "]": begin b_v = 1'b1; b_kind = K_RBRACK; end
                        ";": begin b_v = 1'b1; b_kind = K_SEMI; end
                        ",": begin b_v = 1'b1; b_kind = K_COMMA; end
                        "+": begin b_v = 1'b1; b_kind = K_PLUS; end
                        "-": begin b_v = 1'b1; b_kind = K_MINUS; end
                        "*": begin b_v = 1'b1; b_kind = K_STAR; end
                        "/": begin b_v = 1'b1; b_kind = K_SLASH; end
                        default: begin
                            // unknown byte: error token, then ignore until end
                            b_v    = 1'b1;
                            b_kind = K_ERROR;
                            n_mode = M_HALT;
                        end
                    endcase
                end
            end
        end
    end

    // pack the candidates into queue slots, the last one marked
    always_comb begin
        n_res = 2'(a_v) + 2'(b_v);
        s1    = mk_res(b_kind, r_line, b_start, b_len, b_cv, 1'b1);
        if (a_v) begin
            s0 = mk_res(a_kind, r_line, a_start, a_len, a_cv, !b_v);
        end else begin
            s0 = s1;
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (go) begin
            r_in_vld <= 1'b0;
        end
        if (in_acc) begin
            r_in <= i_in_req;
        end
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_line   <= LINE_BITS'(1);
            r_pos    <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_mask   <= '1;
            r_held   <= 8'h00;
        end else if (go) begin
            r_mode   <= n_mode;
            r_line   <= n_line;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_mask   <= n_mask;
            r_held   <= n_held;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (go) begin
                r_wp <= r_wp + n_res;
            end
            if (out_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (go ? 3'(n_res) : 3'd0) - 3'(out_pop);
        end
    end

    // result queue entries
    always_ff @(posedge i_clk) begin
        if (go && (n_res != 2'd0)) begin
            r_q[r_wp] <= s0;
        end
        if (go && (n_res == 2'd2)) begin
            r_q[r_wp + 2'd1] <= s1;
        end
    end

    // queue never holds more than its four entries
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overfilled");

    // an end request leaves the lexer idle on line one at offset zero
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (r_in.op == OP_END) |=> (r_mode == M_IDLE) && (r_pos == '0) &&
        (r_line == LINE_BITS'(1)))
        else $error("end request did not reset the lexer");

    // once halted only an end request leaves the halt mode
    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (r_mode == M_HALT) && (r_in.op == OP_CHAR) |=>
        (r_mode == M_HALT) && $stable(r_pos))
        else $error("halted lexer moved on");

    // of two results only the second closes the run
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && (n_res == 2'd2) |-> !s0.last_of_run && s1.last_of_run)
        else $error("wrong last-of-run marking");

endmodule

[verif/tb_token_lexer.sv]
// tb_token_lexer: self-checking testbench for the token lexer, with a token
// tracker class that predicts and checks every token; depends on tl_pkg and token_lexer
module tb_token_lexer;
    import tl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // predicts the token stream from accepted requests and checks the results
    class token_tracker;
        t_mode       mode;
        logic [15:0] line_cnt;
        logic [23:0] pos;
        logic [23:0] tok_start;
        logic [15:0] tok_len;
        logic [11:0] kw_mask;
        logic [7:0]  held;
        t_res        tokens_due[$];
        int          n_checked;
        int          n_errors;
        bit [38:0]   kinds_seen;

        function new();
            clear_state();
            n_checked = 0;
            n_errors = 0;
            kinds_seen = '0;
        endfunction

        function void clear_state();
            mode = M_IDLE;
            line_cnt = 16'd1;
            pos = '0;
            tok_start = '0;
            tok_len = '0;
            kw_mask = '1;
            held = '0;
        endfunction

        function bit is_alpha(logic [7:0] c);
            return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // anything outside this set raises an error token
        function bit is_lexable(logic [7:0] c);
            string syms;
            syms = "=><!'\"(){}[];,+-*/ \t\n";
            if (is_alpha(c) || is_digit(c)) return 1'b1;
            for (int i = 0; i < syms.len(); i++)
                if (syms[i] == c) return 1'b1;
            return 1'b0;
        endfunction

        function void emit(logic [5:0] kind, logic [23:0] start, logic [15:0] len,
                           logic [7:0] cv);
            t_res r;
            r.token_kind = kind;
            r.line_number = line_cnt;
            r.start_offset = start;
            r.lexeme_length = len;
            r.char_value = cv;
            r.last_of_run = 1'b0;
            tokens_due.push_back(r);
        endfunction

        function void start_tok(t_mode m, logic [23:0] p);
            mode = m;
            tok_start = p;
            tok_len = 16'd1;
        endfunction

        // drop keyword candidates whose character at idx differs
        function void narrow(logic [7:0] c, logic [15:0] idx);
            for (int k = 0; k < KW_COUNT; k++) begin
                if (idx >= 16'(KW_MAXLEN)) kw_mask[k] = 1'b0;
                else if (KW_TEXT[k][idx[2:0]] != c) kw_mask[k] = 1'b0;
            end
        endfunction

        function logic [5:0] ident_kind();
            for (int k = 0; k < KW_COUNT; k++)
                if (kw_mask[k] && tok_len == 16'(KW_LEN[k])) return 6'(k + 1);
            return K_ID;
        endfunction

        function void flush_pending();
            case (mode)
                M_IDENT: emit(ident_kind(), tok_start, tok_len, 8'd0);
                M_NUM:   emit(K_NUM, tok_start, tok_len, 8'd0);
                M_EQ:    emit(K_ASSIGN, tok_start, 16'd1, "=");
                M_GT:    emit(K_GT, tok_start, 16'd1, ">");
                M_LT:    emit(K_LT, tok_start, 16'd1, "<");
                M_BANG:  emit(K_BANG, tok_start, 16'd1, "!");
                default: ;
            endcase
            mode = M_IDLE;
        endfunction

        // a character seen with no token open
        function void lex_fresh(logic [7:0] c, logic [23:0] p);
            logic [5:0] kind;
            kind = K_ERROR;
            if (c == " " || c == 8'h09) return;
            if (c == 8'h0A) begin
                if (line_cnt != '1) line_cnt++;
                return;
            end
            if (is_alpha(c)) begin
                start_tok(M_IDENT, p);
                kw_mask = '1;
                narrow(c, 16'd0);
                return;
            end
            if (is_digit(c)) begin
                start_tok(M_NUM, p);
                return;
            end
            case (c)
                "=":  begin start_tok(M_EQ, p); return; end
                ">":  begin start_tok(M_GT, p); return; end
                "<":  begin start_tok(M_LT, p); return; end
                "!":  begin start_tok(M_BANG, p); return; end
                "'":  begin start_tok(M_CHOPEN, p); return; end
                "\"": begin start_tok(M_STR, p); return; end
                "(":  kind = K_LPAREN;
                ")":  kind = K_RPAREN;
                "{":  kind = K_LBRACE;
                "}":  kind = K_RBRACE;
                "[":  kind = K_LBRACK;
                "]":  kind = K_RBRACK;
                ";":  kind = K_SEMI;
                ",":  kind = K_COMMA;
                "+":  kind = K_PLUS;
                "-":  kind = K_MINUS;
                "*":  kind = K_STAR;
                "/":  kind = K_SLASH;
                default: begin
                    emit(K_ERROR, p, 16'd1, c);
                    mode = M_HALT;
                    return;
                end
            endcase
            emit(kind, p, 16'd1, c);
        endfunction

        // called for every accepted request
        function void lex_request(t_req r);
            int          n_due_prev;
            logic [7:0]  c;
            logic [23:0] p;
            t_res        last;
            n_due_prev = tokens_due.size();
            c = r.char_code;
            if (r.op == OP_END) begin
                if (mode == M_CHOPEN || mode == M_STR)
                    emit(K_NOQUOTE, tok_start, tok_len, 8'd0);
                else if (mode == M_CHVAL)
                    emit(K_NOQUOTE, tok_start, tok_len, held);
                else if (mode >= M_IDENT && mode <= M_BANG)
                    flush_pending();
                emit(K_END, pos, 16'd0, 8'd0);
                clear_state();
            end else if (mode != M_HALT) begin
                p = pos;
                if (pos != '1) pos++;
                case (mode)
                    M_IDENT: begin
                        if (is_alpha(c)) begin
                            narrow(c, tok_len);
                            if (tok_len != '1) tok_len++;
                        end else begin
                            flush_pending();
                            lex_fresh(c, p);
                        end
                    end
                    M_NUM: begin
                        if (is_digit(c)) begin
                            if (tok_len != '1) tok_len++;
                        end else begin
                            flush_pending();
                            lex_fresh(c, p);
                        end
                    end
                    M_EQ, M_GT, M_LT, M_BANG: begin
                        if (c == "=") begin
                            emit(mode == M_EQ ? K_EQEQ : mode == M_GT ? K_GE :
                                 mode == M_LT ? K_LE : K_NE, tok_start, 16'd2, 8'd0);
                            mode = M_IDLE;
                        end else begin
                            flush_pending();
                            lex_fresh(c, p);
                        end
                    end
                    M_CHOPEN: begin
                        held = c;
                        tok_len = 16'd2;
                        mode = M_CHVAL;
                    end
                    M_CHVAL: begin
                        tok_len = 16'd3;
                        emit(c == "'" ? K_CHARLIT : K_NOQUOTE, tok_start, 16'd3, held);
                        mode = M_IDLE;
                    end
                    M_STR: begin
                        if (tok_len != '1) tok_len++;
                        if (c == "\"") begin
                            emit(K_STR, tok_start, tok_len, 8'd0);
                            mode = M_IDLE;
                        end
                    end
                    default: lex_fresh(c, p);
                endcase
            end
            if (tokens_due.size() > n_due_prev) begin
                last = tokens_due.pop_back();
                last.last_of_run = 1'b1;
                tokens_due.push_back(last);
            end
        endfunction

        function string show(t_res r);
            return $sformatf("kind %0d line %0d start %0d len %0d char %02h last %0b",
                             r.token_kind, r.line_number, r.start_offset,
                             r.lexeme_length, r.char_value, r.last_of_run);
        endfunction

        // called for every accepted result
        function void check_token(t_res got);
            t_res want;
            n_checked++;
            if (got.token_kind <= 6'd38) kinds_seen[got.token_kind] = 1'b1;
            if (tokens_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: token %0d with none expected: %s", n_checked, show(got));
                return;
            end
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind || got.line_number !== want.line_number ||
                got.start_offset !== want.start_offset ||
                got.lexeme_length !== want.lexeme_length ||
                got.char_value !== want.char_value || got.last_of_run !== want.last_of_run) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("ERROR: token %0d expected %s", n_checked, show(want));
                    $display("ERROR: token %0d actual   %s", n_checked, show(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out_res;

    logic hold_off = 1'b0;   // long receiver hold-off in progress
    logic no_idle = 1'b0;    // stretch with no gaps on either side
    int   n_sent = 0;

    token_tracker tracker = new();

    token_lexer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle cycles before the next request or after a result, zero in quiet stretches
    function automatic int idle_cycles();
        if (no_idle || hold_off) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    // offer one request, return at the edge that takes it
    task automatic send_req(input t_req r);
        int gap;
        gap = idle_cycles();
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.lex_request(r);
        n_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        t_req r;
        r.op = OP_CHAR;
        r.char_code = c;
        send_req(r);
    endtask

    // end of text, the ignored byte is random
    task automatic send_end();
        t_req r;
        r.op = OP_END;
        r.char_code = 8'($urandom_range(0, 255));
        send_req(r);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    function automatic logic [7:0] rand_alpha();
        int x;
        x = $urandom_range(0, 52);
        if (x < 26) return 8'("a" + x);
        if (x < 52) return 8'("A" + x - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // one lexically shaped fragment with random content; fragments run together
    // with no separator, so token boundaries come out of the mix as well
    task automatic send_fragment();
        int         pick, n, k;
        logic [7:0] c;
        string      punct;
        punct = "(){}[];,+-*/";
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // whole keyword
            k = $urandom_range(0, KW_COUNT - 1);
            for (int i = 0; i < KW_LEN[k]; i++) send_char(KW_TEXT[k][i]);
        end else if (pick < 25) begin
            // near miss: a keyword prefix, or a keyword with one more character
            k = $urandom_range(0, KW_COUNT - 1);
            n = $urandom_range(1, KW_LEN[k]);
            for (int i = 0; i < n; i++) send_char(KW_TEXT[k][i]);
            if (n == KW_LEN[k])
                send_char($urandom_range(0, 3) == 0 ? rand_digit() : rand_alpha());
        end else if (pick < 38) begin
            n = $urandom_range(1, 8);
            send_char(rand_alpha());
            for (int i = 1; i < n; i++)
                send_char($urandom_range(0, 4) == 0 ? rand_digit() : rand_alpha());
        end else if (pick < 47) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) send_char(rand_digit());
        end else if (pick < 57) begin
            // comparison and assignment operators, paired or lone
            case ($urandom_range(0, 3))
                0: send_char("=");
                1: send_char(">");
                2: send_char("<");
                default: send_char("!");
            endcase
            if ($urandom_range(0, 1) == 1) send_char("=");
        end else if (pick < 66) begin
            send_char(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 74) begin
            // char literal with any byte inside, sometimes without its closing quote
            send_char("'");
            send_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0) send_char("'");
            else send_char(8'($urandom_range(0, 255)));
        end else if (pick < 81) begin
            send_char("\"");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                k = $urandom_range(0, 9);
                if (k < 7) c = 8'($urandom_range(32, 126));
                else if (k == 7) c = 8'h0A;
                else c = 8'($urandom_range(0, 255));
                send_char(c);
            end
            if ($urandom_range(0, 6) != 0) send_char("\"");
        end else if (pick < 93) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                case ($urandom_range(0, 2))
                    0: send_char(" ");
                    1: send_char(8'h09);
                    default: send_char(8'h0A);
                endcase
            end
        end else if (pick < 96) begin
            // unknown byte halts the lexer, bytes after it are dropped until the end
            do c = 8'($urandom_range(0, 255)); while (tracker.is_lexable(c));
            send_char(c);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) send_char(8'($urandom_range(0, 255)));
            send_end();
        end else begin
            send_end();
        end
    endtask

    // result side: take a result, then stall for a drawn number of cycles
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.check_token(o_out_res);
                stall_left = idle_cycles();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= hold_off || stall_left > 0;
        end
    end

    // alternate between gappy stretches and stretches with no gaps at all
    initial begin
        forever begin
            repeat ($urandom_range(200, 600)) @(posedge i_clk);
            no_idle <= 1'b1;
            repeat ($urandom_range(50, 200)) @(posedge i_clk);
            no_idle <= 1'b0;
        end
    end

    // long result hold-off while requests keep coming, so the queue fills
    // and the request side stalls
    initial begin
        repeat (2000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
        repeat (12000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d tokens still expected", tracker.tokens_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: keyword ended by a not-equal, lone bang, char literal and
        // string holding a newline, number ended by a lone greater-than
        send_text("while!=! '\n'\"\n\"9>\t");
        send_end();
        // operator pending at the end, then an error on a zero byte and a
        // dropped top byte while halted
        send_text("<");
        send_end();
        send_char(8'h00);
        send_char(8'hFF);
        send_end();

        while (n_sent < 1750) send_fragment();
        send_end();
        i_in_valid <= 1'b0;

        while (tracker.tokens_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d requests and %0d tokens, %0d of 39 token kinds seen",
                 n_sent, tracker.n_checked, $countones(tracker.kinds_seen));
        $display("%0d mismatches", tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.tokens_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
